// ===== rtl/abkf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the angle/bias Kalman filter.
`timescale 1ns / 1ps
`default_nettype none
package abkf_pkg;

  localparam int STATE_FRAC_BITS_DEF = 32;
  localparam int STATE_W = 48;
  localparam int IN_FRAC = 16;
  localparam int REG_FRAC = 24;

  typedef enum logic [1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_BIAS  = 2'd1,
    REG_R       = 2'd2,
    REG_DT      = 2'd3
  } abkf_reg_e;

  typedef struct packed {
    logic [31:0] q_angle;
    logic [31:0] q_bias;
    logic [31:0] r;
    logic [31:0] dt;
  } abkf_cfg_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } abkf_op_e;

  typedef struct packed {
    logic     start;
    abkf_op_e op;
  } abkf_req_t;

  typedef enum logic [2:0] {
    U_IDLE, U_MUL, U_DIV, U_FIN, U_DONE
  } abkf_ustate_e;

  typedef enum logic [1:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_OUT
  } abkf_state_e;

  typedef enum logic [3:0] {
    STEP_PRED_ANGLE, STEP_PRED_T1, STEP_PRED_T2, STEP_PRED_T3,
    STEP_DIV_K0, STEP_DIV_K1, STEP_CORR_ANGLE, STEP_CORR_BIAS,
    STEP_COV_AA, STEP_COV_AB, STEP_COV_BA, STEP_COV_BB
  } abkf_step_e;

  // saturate a magnitude with sign to 48-bit two's complement
  function automatic logic signed [47:0] sat48(logic neg, logic [127:0] mag);
    logic [127:0] lim;
    lim = 128'd1 << 47;
    if (neg) begin
      if (mag >= lim) return 48'sh800000000000;
      return -$signed(mag[47:0]);
    end
    if (mag >= lim) return 48'sh7fffffffffff;
    return $signed(mag[47:0]);
  endfunction

  function automatic logic [47:0] mag48(logic signed [47:0] x);
    return x[47] ? 48'(-x) : 48'(x);
  endfunction

  function automatic logic signed [47:0] sadd(logic signed [47:0] a, logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) return s[48] ? 48'sh800000000000 : 48'sh7fffffffffff;
    return s[47:0];
  endfunction

  function automatic logic signed [47:0] ssub(logic signed [47:0] a, logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} - {b[47], b};
    if (s[48] != s[47]) return s[48] ? 48'sh800000000000 : 48'sh7fffffffffff;
    return s[47:0];
  endfunction

  // bring a 33-bit signed value with 'from' fraction bits to the state format
  function automatic logic signed [47:0] to_state(logic signed [32:0] x, int from, int f);
    logic [63:0] m;
    logic        neg;
    int          sh;
    neg = x[32];
    m = neg ? 64'(-$signed({x[32], x})) : 64'($signed({x[32], x}));
    if (f >= from) begin
      sh = f - from;
      if (m > ((64'd1 << 62) >> sh)) m = 64'd1 << 62;
      else m = m << sh;
    end else begin
      sh = from - f;
      m = (m + (64'd1 << (sh - 1))) >> sh;
    end
    return sat48(neg, 128'(m));
  endfunction

  // state format to signed Q16.16, rounded and saturated
  function automatic logic [31:0] to_out(logic signed [47:0] x, int f);
    logic [63:0] m;
    logic        neg;
    int          sh;
    neg = x[47];
    m = 64'(mag48(x));
    sh = f - IN_FRAC;
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    if (neg) begin
      if (m >= 64'h80000000) return 32'h80000000;
      return 32'(-m);
    end
    if (m >= 64'h80000000) return 32'h7fffffff;
    return m[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/abkf_cfg.sv =====
// APB register file holding the filter noise and period settings.
`timescale 1ns / 1ps
`default_nettype none
module abkf_cfg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output abkf_pkg::abkf_cfg_t   cfg
);
  import abkf_pkg::*;

  abkf_cfg_t cfg_r;
  abkf_reg_e sel;

  assign sel = abkf_reg_e'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.q_angle <= 32'd16777;
      cfg_r.q_bias  <= 32'd50332;
      cfg_r.r       <= 32'd8388608;
      cfg_r.dt      <= 32'd167772;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_Q_ANGLE: cfg_r.q_angle <= pwdata;
        REG_Q_BIAS:  cfg_r.q_bias  <= pwdata;
        REG_R:       cfg_r.r       <= pwdata;
        REG_DT:      cfg_r.dt      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_Q_ANGLE: prdata = cfg_r.q_angle;
      REG_Q_BIAS:  prdata = cfg_r.q_bias;
      REG_R:       prdata = cfg_r.r;
      REG_DT:      prdata = cfg_r.dt;
      default:     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

// ===== rtl/abkf_alu.sv =====
// Shared multi-cycle unit: rounded fixed-point multiply and restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module abkf_alu #(
  parameter int STATE_FRAC_BITS = abkf_pkg::STATE_FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire abkf_pkg::abkf_req_t req,
  input  wire logic signed [47:0]  a,
  input  wire logic signed [47:0]  b,
  output logic                     done,
  output logic signed [47:0]       result
);
  import abkf_pkg::*;

  localparam int F  = STATE_FRAC_BITS;
  localparam int NW = STATE_W + F + 2;   // dividend bits
  localparam int CW = $clog2(NW);

  abkf_ustate_e st_r, st_nxt;
  abkf_op_e     op_r;
  logic [CW-1:0] cnt_r;
  logic [47:0]  ma_r, mb_r;
  logic         neg_r;
  logic [95:0]  acc_r;
  logic [NW-1:0] num_r;
  logic [48:0]  dv_r;
  logic [49:0]  rem_r;
  logic [47:0]  q_r;
  logic         ovf_r;
  logic signed [47:0] res_r;

  logic [23:0]  ah, bh;
  logic [47:0]  pp;
  logic [95:0]  pp_sh;
  logic [49:0]  remsh;
  logic         ge;
  logic [96:0]  rsum;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      U_IDLE: if (req.start) st_nxt = (req.op == OP_DIV) ? U_DIV : U_MUL;
      U_MUL:  if (cnt_r[1:0] == 2'd3) st_nxt = U_FIN;
      U_DIV:  if (cnt_r == '0) st_nxt = U_FIN;
      U_FIN:  st_nxt = U_DONE;
      U_DONE: st_nxt = U_IDLE;
      default: st_nxt = U_IDLE;
    endcase
  end

  always_comb begin
    done = (st_r == U_DONE);
  end

  assign ah = cnt_r[0] ? ma_r[47:24] : ma_r[23:0];
  assign bh = cnt_r[1] ? mb_r[47:24] : mb_r[23:0];
  assign pp = ah * bh;
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    pp_sh = 96'(pp);
      2'd3:    pp_sh = 96'(pp) << 48;
      default: pp_sh = 96'(pp) << 24;
    endcase
  end

  assign remsh = {rem_r[48:0], num_r[NW-1]};
  assign ge    = remsh >= 50'(dv_r);
  assign rsum  = 97'(acc_r) + (97'd1 << (F - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= U_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      U_IDLE: begin
        if (req.start) begin
          op_r  <= req.op;
          ma_r  <= mag48(a);
          neg_r <= (req.op == OP_DIV) ? a[47] : (a[47] ^ b[47]);
          acc_r <= '0;
          rem_r <= '0;
          q_r   <= '0;
          ovf_r <= 1'b0;
          if (req.op == OP_DIV) begin
            mb_r  <= 48'(b);
            num_r <= (NW'(mag48(a)) << (F + 1)) + NW'(48'(b));
            dv_r  <= {48'(b), 1'b0};
            cnt_r <= CW'(NW - 1);
          end else begin
            mb_r  <= mag48(b);
            cnt_r <= '0;
          end
        end
      end
      U_MUL: begin
        acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + CW'(1);
      end
      U_DIV: begin
        num_r <= num_r << 1;
        rem_r <= ge ? remsh - 50'(dv_r) : remsh;
        ovf_r <= ovf_r | q_r[47];
        q_r   <= {q_r[46:0], ge};
        cnt_r <= cnt_r - CW'(1);
      end
      U_FIN: begin
        if (op_r == OP_DIV) res_r <= sat48(neg_r, ovf_r ? (128'd1 << 48) : 128'(q_r));
        else                res_r <= sat48(neg_r, 128'(rsum >> F));
      end
      default: ;
    endcase
  end

  assign result = res_r;
endmodule
`default_nettype wire

// ===== rtl/angle_bias_kalman_filter.sv =====
// Top level: two-state angle/gyro-bias Kalman filter with stream ports and APB setup.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  in_*  : one word per sensor sample, tdata = {gyro_rate, observed_angle}, Q16.16.
//  out_* : one word per sample, tdata = {bias_estimate, angle_estimate}, Q16.16,
//          rounded and saturated.
//  cfg_* : APB registers Q_angle @0x0, Q_bias @0x4, R @0x8, dt @0xC (Q8.24).
//          Write only while the filter is idle.
// One sample runs through a sequencer that issues ten multiplies and two divides
// to a single shared unit. A multiply sums four 24x24 partial products and
// then rounds; a divide yields one quotient bit per cycle over a 48+F+2 bit
// dividend. When P00+R is not positive the divides are skipped and both gains
// are set to zero. in_tready is high only while the sequencer is idle, so one
// sample is in work at a time. The next can be taken while a result still sits
// in the output register. If the receiver stalls, a finished result waits
// before the output register until the previous word is taken.
// Reset (synchronous, rst_n low) restores register defaults, zero angle and
// bias, identity covariance, and drops any pending word.
module angle_bias_kalman_filter #(
  parameter int STATE_FRAC_BITS = abkf_pkg::STATE_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,    // [31:0] observed_angle, [63:32] gyro_rate
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,   // [31:0] angle_estimate, [63:32] bias_estimate
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import abkf_pkg::*;

  localparam int F = STATE_FRAC_BITS;

  abkf_cfg_t cfg;
  abkf_req_t req;
  logic      alu_done;
  logic signed [47:0] alu_res, op_a, op_b;

  abkf_state_e st_r, st_nxt;
  abkf_step_e  step_r;

  // filter state
  logic signed [47:0] angle_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  // per-sample scratch
  logic signed [47:0] t1_r, t2_r, p00_r, p01_r, p10_r, p11_r, den_r, k0_r, k1_r, y_r;
  logic [31:0] obs_raw_r, rate_raw_r;
  logic [31:0] ang_o_r, bias_o_r;
  logic        out_valid_r;

  logic signed [47:0] dt, qa, qb, rr, obs, rate;
  logic signed [47:0] p00_w, den_w;
  logic               den_pos;
  logic               out_free;

  abkf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  abkf_alu #(.STATE_FRAC_BITS(STATE_FRAC_BITS)) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .a      (op_a),
    .b      (op_b),
    .done   (alu_done),
    .result (alu_res)
  );

  assign cfg_pready = 1'b1;

  // registers and inputs in state format
  assign dt   = to_state({1'b0, cfg.dt}, REG_FRAC, F);
  assign qa   = to_state({1'b0, cfg.q_angle}, REG_FRAC, F);
  assign qb   = to_state({1'b0, cfg.q_bias}, REG_FRAC, F);
  assign rr   = to_state({1'b0, cfg.r}, REG_FRAC, F);
  assign obs  = to_state({obs_raw_r[31], obs_raw_r}, IN_FRAC, F);
  assign rate = to_state({rate_raw_r[31], rate_raw_r}, IN_FRAC, F);

  // predicted P00 once dt^2*P11 (alu_res at the last predict step) is in
  assign p00_w   = sadd(sadd(ssub(aa_r, t1_r), alu_res), qa);
  assign den_w   = sadd(p00_w, rr);
  assign den_pos = !den_w[47] && (den_w != '0);
  assign out_free = !out_valid_r || out_tready;

  // operand select per step
  always_comb begin
    op_a = k0_r;
    op_b = y_r;
    case (step_r)
      STEP_PRED_ANGLE: begin op_a = ssub(rate, bias_r); op_b = dt; end
      STEP_PRED_T1:    begin op_a = sadd(ab_r, ba_r);   op_b = dt; end
      STEP_PRED_T2:    begin op_a = bb_r;  op_b = dt;    end
      STEP_PRED_T3:    begin op_a = t2_r;  op_b = dt;    end
      STEP_DIV_K0:     begin op_a = p00_r; op_b = den_r; end
      STEP_DIV_K1:     begin op_a = p10_r; op_b = den_r; end
      STEP_CORR_ANGLE: begin op_a = k0_r;  op_b = y_r;   end
      STEP_CORR_BIAS:  begin op_a = k1_r;  op_b = y_r;   end
      STEP_COV_AA:     begin op_a = k0_r;  op_b = p00_r; end
      STEP_COV_AB:     begin op_a = k0_r;  op_b = p01_r; end
      STEP_COV_BA:     begin op_a = k1_r;  op_b = p00_r; end
      STEP_COV_BB:     begin op_a = k1_r;  op_b = p01_r; end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (in_tvalid) st_nxt = S_ISSUE;
      S_ISSUE: st_nxt = S_WAIT;
      S_WAIT:  if (alu_done) st_nxt = (step_r == STEP_COV_BB) ? S_OUT : S_ISSUE;
      S_OUT:   if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = (st_r == S_IDLE);
    req.start = (st_r == S_ISSUE);
    req.op    = (step_r == STEP_DIV_K0 || step_r == STEP_DIV_K1) ? OP_DIV : OP_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r     <= '0;
      bias_r      <= '0;
      aa_r        <= 48'sd1 <<< F;
      ab_r        <= '0;
      ba_r        <= '0;
      bb_r        <= 48'sd1 <<< F;
      out_valid_r <= 1'b0;
      step_r      <= STEP_PRED_ANGLE;
    end else begin
      if (st_r == S_IDLE && in_tvalid) begin
        obs_raw_r  <= in_tdata[31:0];
        rate_raw_r <= in_tdata[63:32];
        step_r     <= STEP_PRED_ANGLE;
      end

      if (st_r == S_WAIT && alu_done) begin
        unique case (step_r)
          STEP_PRED_ANGLE: begin
            angle_r <= sadd(angle_r, alu_res);
            step_r  <= STEP_PRED_T1;
          end
          STEP_PRED_T1: begin
            t1_r   <= alu_res;
            step_r <= STEP_PRED_T2;
          end
          STEP_PRED_T2: begin
            t2_r   <= alu_res;
            step_r <= STEP_PRED_T3;
          end
          STEP_PRED_T3: begin
            p00_r <= p00_w;
            p01_r <= ssub(ab_r, t2_r);
            p10_r <= ssub(ba_r, t2_r);
            p11_r <= sadd(bb_r, qb);
            den_r <= den_w;
            y_r   <= ssub(obs, angle_r);
            if (den_pos) begin
              step_r <= STEP_DIV_K0;
            end else begin
              // no usable denominator: zero gains
              k0_r   <= '0;
              k1_r   <= '0;
              step_r <= STEP_CORR_ANGLE;
            end
          end
          STEP_DIV_K0: begin
            k0_r   <= alu_res;
            step_r <= STEP_DIV_K1;
          end
          STEP_DIV_K1: begin
            k1_r   <= alu_res;
            step_r <= STEP_CORR_ANGLE;
          end
          STEP_CORR_ANGLE: begin
            angle_r <= sadd(angle_r, alu_res);
            step_r  <= STEP_CORR_BIAS;
          end
          STEP_CORR_BIAS: begin
            bias_r <= sadd(bias_r, alu_res);
            step_r <= STEP_COV_AA;
          end
          STEP_COV_AA: begin
            aa_r   <= ssub(p00_r, alu_res);
            step_r <= STEP_COV_AB;
          end
          STEP_COV_AB: begin
            ab_r   <= ssub(p01_r, alu_res);
            step_r <= STEP_COV_BA;
          end
          STEP_COV_BA: begin
            ba_r   <= ssub(p10_r, alu_res);
            step_r <= STEP_COV_BB;
          end
          STEP_COV_BB: begin
            bb_r   <= ssub(p11_r, alu_res);
            step_r <= STEP_PRED_ANGLE;
          end
          default: step_r <= STEP_PRED_ANGLE;
        endcase
      end

      // hand the result to the output register once it is free
      if (st_r == S_OUT && out_free) begin
        ang_o_r     <= to_out(angle_r, F);
        bias_o_r    <= to_out(bias_r, F);
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {bias_o_r, ang_o_r};
endmodule
`default_nettype wire
